// ----- rtl/three_mask_border_overlay_defines.svh -----
// assertion macros for the mask border overlay checker
`ifndef THREE_MASK_BORDER_OVERLAY_DEFINES_SVH
`define THREE_MASK_BORDER_OVERLAY_DEFINES_SVH

// clocked assertion, off while reset is held
`define TMBO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also runs through reset
`define TMBO_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/tmbo_pkg.sv -----
// package: types, codes and sizes of the mask border overlay
`timescale 1ns / 1ps
`default_nettype none
package tmbo_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int REG_W     = 12;
    localparam int CMP_W     = (EW_W > REG_W) ? EW_W : REG_W;
    localparam int ROW_W     = REG_W + 1;
    localparam int MEM_W     = 30;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] BORDER_ADD = 8'd127;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_OUTER   = 2'd1;
    localparam logic [1:0] KIND_SEGMENT = 2'd2;
    localparam logic [1:0] KIND_LABEL   = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       outer_mask;
        logic       segment_mask;
        logic       label_mask;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] border_kind;
        logic       frame_end;
    } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/tmbo_ram.sv -----
// generic single-clock ram, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module tmbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/three_mask_border_overlay.sv -----
// top level: 3x3 mask border overlay on an rgb pixel stream
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per clock as long as the result side keeps up; a stall on m_ready
// backs up through a single output register and one stage behind it. Each item is
// accepted into stage zero, which issues the line store read and updates the position
// counters; the stage behind it then builds the 3x3 window, writes the line store back
// and loads the output register. The line store is one 30-bit by MAX_WIDTH ram
// (upper-row masks plus the middle-row pixel), read and written at most once per cycle;
// a one-pixel line is served by forwarding the word being written. Results lag the pixel
// stream by one line plus one pixel, and flush items drain the tail of a frame.
// Configuration writes are always ready, take effect at once and, for the line width
// and frame height registers, restart the frame.
module three_mask_border_overlay
    import tmbo_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

    typedef struct packed {
        logic [2:0]        mask;
        logic [23:0]       rgb;
        logic [ADDR_W-1:0] addr;
        logic              mid_ok;
        logic              up_ok;
        logic              first_col;
        logic              centre_first;
        logic              emit;
        logic              last;
    } stage_t;

    logic [REG_W-1:0]  line_width_reg;
    logic [REG_W-1:0]  frame_height_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [ROW_W-1:0]  row_reg;
    stage_t            st_reg;
    stage_t            st_next;
    logic              st_valid_reg;
    logic              fwd_reg;
    logic [MEM_W-1:0]  fwd_data_reg;
    logic [26:0]       window_reg;
    logic [26:0]       window_next;
    logic [23:0]       held_reg;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic              out_valid_reg;

    logic [CMP_W-1:0]  lw_ext;
    logic [EW_W-1:0]   w_eff;
    logic [REG_W-1:0]  h_eff;
    logic              cfg_write;
    logic              s_accept;
    logic              draining;
    logic              push;
    logic              c_last;
    logic              frame_last;
    logic              st_adv;
    logic              ram_we;
    logic [MEM_W-1:0]  ram_rdata;
    logic [MEM_W-1:0]  old_word;
    logic [MEM_W-1:0]  wdata;
    logic [2:0]        mid_m;
    logic [2:0]        up_m;
    logic [26:0]       eval_win;
    logic [2:0]        all_one;
    logic [2:0]        border;
    logic [7:0]        r_half;
    logic [7:0]        g_half;
    logic [7:0]        b_half;

    // effective image size
    always_comb begin
        lw_ext = CMP_W'(line_width_reg);
        if (lw_ext == '0) begin
            w_eff = EW_W'(1);
        end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_eff = EW_W'(lw_ext);
        end
        h_eff = (frame_height_reg == '0) ? REG_W'(1) : frame_height_reg;
    end

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == CFG_LINE_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

    // handshake
    assign st_adv   = !out_valid_reg || m_ready;
    assign s_ready  = !st_valid_reg || st_adv;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    // stage zero: position and read issue
    assign draining   = row_reg >= ROW_W'(h_eff);
    assign push       = s_accept && (draining || s_item.op == OP_PIXEL);
    assign c_last     = (EW_W'(col_reg) + EW_W'(1)) >= w_eff;
    assign frame_last = (row_reg == ROW_W'(h_eff) + ROW_W'(1)) && (col_reg == '0);

    always_comb begin
        st_next.mask = 3'b000;
        st_next.rgb  = '0;
        if (!draining) begin
            st_next.mask = {s_item.label_mask, s_item.segment_mask, s_item.outer_mask};
            st_next.rgb  = {s_item.blue_in, s_item.green_in, s_item.red_in};
        end
        st_next.addr         = col_reg;
        st_next.mid_ok       = row_reg >= ROW_W'(1);
        st_next.up_ok        = row_reg >= ROW_W'(2);
        st_next.first_col    = col_reg == '0;
        st_next.centre_first = (col_reg == '0 && w_eff == EW_W'(1)) ||
                               col_reg == ADDR_W'(1);
        st_next.emit         = row_reg >= ROW_W'(2) ||
                               (row_reg == ROW_W'(1) && col_reg != '0);
        st_next.last         = frame_last;
    end

    // stage one: window, border test, write back
    assign old_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign mid_m    = st_reg.mid_ok ? old_word[26:24] : 3'b000;
    assign up_m     = st_reg.up_ok ? old_word[29:27] : 3'b000;
    assign wdata    = {old_word[26:24], st_reg.mask, st_reg.rgb};
    assign ram_we   = st_valid_reg && st_adv;

    always_comb begin
        window_next = {st_reg.mask, mid_m, up_m, window_reg[26:9]};
        eval_win    = window_next;
        if (st_reg.first_col) begin
            eval_win[26:18] = 9'd0;
        end
        if (st_reg.centre_first) begin
            eval_win[8:0] = 9'd0;
        end
        all_one = 3'b111;
        for (int k = 0; k < 9; k++) begin
            all_one = all_one & eval_win[3*k +: 3];
        end
        border = eval_win[14:12] & ~all_one;
    end

    always_comb begin
        r_half = {1'b0, held_reg[7:1]};
        g_half = {1'b0, held_reg[15:9]};
        b_half = {1'b0, held_reg[23:17]};
        out_next.red_out     = held_reg[7:0];
        out_next.green_out   = held_reg[15:8];
        out_next.blue_out    = held_reg[23:16];
        out_next.border_kind = KIND_NONE;
        out_next.frame_end   = st_reg.last;
        if (border[0]) begin
            out_next.border_kind = KIND_OUTER;
            out_next.red_out     = r_half + BORDER_ADD;
            out_next.green_out   = g_half;
            out_next.blue_out    = b_half;
        end else if (border[1]) begin
            out_next.border_kind = KIND_SEGMENT;
            out_next.red_out     = r_half + BORDER_ADD;
            out_next.green_out   = g_half + BORDER_ADD;
            out_next.blue_out    = b_half + BORDER_ADD;
        end else if (border[2]) begin
            out_next.border_kind = KIND_LABEL;
            out_next.red_out     = r_half;
            out_next.green_out   = g_half + BORDER_ADD;
            out_next.blue_out    = b_half;
        end
    end

    tmbo_ram #(
        .WIDTH(MEM_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(st_reg.addr),
        .wdata(wdata),
        .re   (push),
        .raddr(col_reg),
        .rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= REG_W'(640);
            frame_height_reg <= REG_W'(480);
            col_reg          <= '0;
            row_reg          <= '0;
            st_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            window_reg       <= '0;
            held_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                if (cfg_index == CFG_LINE_WIDTH) begin
                    line_width_reg <= cfg_data;
                end else begin
                    frame_height_reg <= cfg_data;
                end
                col_reg    <= '0;
                row_reg    <= '0;
                window_reg <= '0;
                held_reg   <= '0;
            end else begin
                if (push) begin
                    if (frame_last) begin
                        col_reg <= '0;
                        row_reg <= '0;
                    end else if (c_last) begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end else begin
                        col_reg <= col_reg + ADDR_W'(1);
                    end
                end
                if (ram_we) begin
                    if (st_reg.last) begin
                        window_reg <= '0;
                        held_reg   <= '0;
                    end else begin
                        window_reg <= window_next;
                        held_reg   <= old_word[23:0];
                    end
                end
            end
            if (push) begin
                st_valid_reg <= 1'b1;
                fwd_reg      <= ram_we && (st_reg.addr == col_reg);
            end else if (st_adv) begin
                st_valid_reg <= 1'b0;
            end
            if (st_adv) begin
                out_valid_reg <= st_valid_reg && st_reg.emit;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (push) begin
            st_reg <= st_next;
        end
        if (ram_we) begin
            fwd_data_reg <= wdata;
        end
        if (ram_we && st_reg.emit) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tmbo_checker.sv -----
// port checker for the mask border overlay, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "three_mask_border_overlay_defines.svh"
module tmbo_checker
    import tmbo_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item,
    input wire logic      cfg_valid,
    input wire logic      cfg_ready
);

    logic tint_ok;

    // tint that each border kind leaves on the channels
    always_comb begin
        case (m_item.border_kind)
            KIND_OUTER: begin
                tint_ok = m_item.red_out >= BORDER_ADD && m_item.green_out <= BORDER_ADD &&
                          m_item.blue_out <= BORDER_ADD;
            end
            KIND_SEGMENT: begin
                tint_ok = m_item.red_out >= BORDER_ADD && m_item.green_out >= BORDER_ADD &&
                          m_item.blue_out >= BORDER_ADD;
            end
            KIND_LABEL: begin
                tint_ok = m_item.red_out <= BORDER_ADD && m_item.green_out >= BORDER_ADD &&
                          m_item.blue_out <= BORDER_ADD;
            end
            default: begin
                tint_ok = 1'b1;
            end
        endcase
    end

    `TMBO_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

    `TMBO_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "item changed")

    `TMBO_ASSERT(a_in_stall, s_valid && !s_ready |-> m_valid && !m_ready, "input stalled")

    `TMBO_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "config write refused")

    `TMBO_ASSERT(a_tint, m_valid |-> tint_ok, "border tint wrong")

endmodule

bind three_mask_border_overlay tmbo_checker u_tmbo_checker (.*);
`default_nettype wire

// ----- sim/tb_three_mask_border_overlay.sv -----
// testbench for the 3x3 mask border overlay: directed frames, register extremes,
// backpressure and random frames, checked against an in-bench prediction
`timescale 1ns / 1ps
module tb_three_mask_border_overlay;
    import tmbo_pkg::*;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LINE_WIDTH;
    logic [REG_W-1:0]     cfg_data  = '0;

    three_mask_border_overlay uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // prediction state
    logic [REG_W-1:0]  width_reg;
    logic [REG_W-1:0]  height_reg;
    logic [2:0]        up_masks   [MAX_WIDTH];
    logic [26:0]       mid_pixels [MAX_WIDTH];
    logic [26:0]       win_masks;
    logic [23:0]       held_rgb;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       out_count;

    out_item_t         pending_pixels[$];
    int unsigned       err_count     = 0;
    int unsigned       items_done    = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       hold_req      = 0;
    int unsigned       hold_left     = 0;
    int unsigned       stall_cycles  = 0;

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic void restart_frame();
        win_masks = '0;
        held_rgb  = '0;
        col_pos   = 0;
        row_pos   = 0;
        out_count = 0;
    endfunction

    function automatic bit is_mask_edge(input logic [26:0] win, input int m);
        if (!win[12+m]) return 1'b0;
        for (int k = 0; k < 9; k++)
            if (!win[3*k+m]) return 1'b1;
        return 1'b0;
    endfunction

    // advances the prediction by one accepted item, returns 1 when a pixel comes out
    function automatic bit compute_overlay(input in_item_t it, output out_item_t res);
        int unsigned w, h, total, c, centre;
        bit          draining, emit;
        logic [26:0] pix, old_mid, next_win, eval;
        logic [2:0]  mid_m, up_m;
        logic [7:0]  r, g, b;
        logic [1:0]  kind;
        w        = eff_width();
        h        = eff_height();
        total    = w * h;
        res      = '0;
        draining = (row_pos >= h);
        if (!draining && it.op == OP_FLUSH) return 1'b0;
        pix = draining ? '0 : {it.label_mask, it.segment_mask, it.outer_mask,
                               it.blue_in, it.green_in, it.red_in};
        c       = (col_pos >= w) ? 0 : col_pos;
        old_mid = mid_pixels[c];
        mid_m   = (row_pos >= 1) ? old_mid[26:24] : 3'b000;
        up_m    = (row_pos >= 2) ? up_masks[c] : 3'b000;
        up_masks[c]   = old_mid[26:24];
        mid_pixels[c] = pix;
        next_win = {pix[26:24], mid_m, up_m, win_masks[26:9]};
        eval     = next_win;
        if (c == 0) eval[26:18] = '0;
        centre = (c == 0) ? w - 1 : c - 1;
        if (centre == 0) eval[8:0] = '0;
        emit = (row_pos >= 2) || (row_pos == 1 && c >= 1);
        {b, g, r} = held_rgb;
        win_masks = next_win;
        held_rgb  = old_mid[23:0];
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
        if (!emit) return 1'b0;
        kind = KIND_NONE;
        if (is_mask_edge(eval, 0)) begin
            kind = KIND_OUTER;
            r = (r >> 1) + BORDER_ADD;
            g = g >> 1;
            b = b >> 1;
        end else if (is_mask_edge(eval, 1)) begin
            kind = KIND_SEGMENT;
            r = (r >> 1) + BORDER_ADD;
            g = (g >> 1) + BORDER_ADD;
            b = (b >> 1) + BORDER_ADD;
        end else if (is_mask_edge(eval, 2)) begin
            kind = KIND_LABEL;
            r = r >> 1;
            g = (g >> 1) + BORDER_ADD;
            b = b >> 1;
        end
        out_count++;
        res.red_out     = r;
        res.green_out   = g;
        res.blue_out    = b;
        res.border_kind = kind;
        res.frame_end   = (out_count >= total);
        if (res.frame_end) restart_frame();
        return 1'b1;
    endfunction

    function automatic in_item_t make_pixel(input int unsigned d_outer, d_segment, d_label);
        in_item_t it;
        it.op           = OP_PIXEL;
        it.red_in       = 8'($urandom_range(0, 255));
        it.green_in     = 8'($urandom_range(0, 255));
        it.blue_in      = 8'($urandom_range(0, 255));
        it.outer_mask   = ($urandom_range(0, 99) < d_outer);
        it.segment_mask = ($urandom_range(0, 99) < d_segment);
        it.label_mask   = ($urandom_range(0, 99) < d_label);
        return it;
    endfunction

    function automatic in_item_t flush_item();
        in_item_t it;
        it    = in_item_t'($urandom);
        it.op = OP_FLUSH;
        return it;
    endfunction

    function automatic int unsigned pick_density();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 30;
            2: return 70;
            3: return 95;
            default: return 100;
        endcase
    endfunction

    task automatic send_item(input in_item_t it);
        out_item_t res;
        bit        ignored;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        ignored = (row_pos < eff_height()) && (it.op == OP_FLUSH);
        if (compute_overlay(it, res)) pending_pixels.push_back(res);
        if (!ignored) items_done++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_LINE_WIDTH) begin
            width_reg = val;
            restart_frame();
        end else if (idx == CFG_FRAME_HEIGHT) begin
            height_reg = val;
            restart_frame();
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_config();
        int unsigned pick, sel;
        pick = $urandom_range(0, 2);
        sel  = $urandom_range(0, 99);
        if (pick != 2)
            write_config(CFG_LINE_WIDTH, (sel < 10) ? 12'd0 :
                         (sel < 80) ? 12'($urandom_range(1, 8)) : 12'($urandom_range(9, 40)));
        if (pick != 1) write_config(CFG_FRAME_HEIGHT, 12'($urandom_range(0, 6)));
    endtask

    task automatic send_pixels(input int unsigned n, d_outer, d_segment, d_label, noise_pct);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(flush_item());
            send_item(make_pixel(d_outer, d_segment, d_label));
        end
    endtask

    // drain ticks until the frame closes, some of them carrying pixel data
    task automatic drain_frame();
        while (row_pos >= eff_height()) begin
            if ($urandom_range(0, 9) < 3) send_item(make_pixel(50, 50, 50));
            else send_item(flush_item());
        end
    endtask

    task automatic test_directed_frames();
        in_item_t px;
        write_config(CFG_LINE_WIDTH, 3);
        write_config(CFG_FRAME_HEIGHT, 3);
        // flush before the frame is complete, ignored
        px    = '1;
        px.op = OP_FLUSH;
        send_item(px);
        for (int k = 0; k < 9; k++) begin
            px.op           = OP_PIXEL;
            px.red_in       = (k % 2 == 1) ? 8'hFF : 8'h00;
            px.green_in     = (k % 3 == 0) ? 8'hFF : 8'h00;
            px.blue_in      = (k > 4) ? 8'hFF : 8'h01;
            px.outer_mask   = (k == 0);
            px.segment_mask = 1'b1;
            px.label_mask   = (k != 8);
            send_item(px);
        end
        // pixel after the frame is in acts as a drain tick
        px    = '1;
        px.op = OP_PIXEL;
        send_item(px);
        drain_frame();
        write_config(CFG_LINE_WIDTH, 1);
        write_config(CFG_FRAME_HEIGHT, 1);
        px              = '0;
        px.red_in       = 8'hFF;
        px.green_in     = 8'hFF;
        px.blue_in      = 8'hFF;
        send_item(px);
        drain_frame();
    endtask

    task automatic test_register_extremes();
        write_config(CFG_LINE_WIDTH, 0);
        write_config(CFG_FRAME_HEIGHT, 0);
        send_pixels(1, 50, 50, 50, 0);
        drain_frame();
        // width above the line store size, warm-up part of the first line only
        write_config(CFG_LINE_WIDTH, 12'hFFF);
        write_config(CFG_FRAME_HEIGHT, 2);
        send_pixels(40, 50, 50, 50, 0);
        write_config(CFG_FRAME_HEIGHT, 12'hFFF);
        write_config(CFG_LINE_WIDTH, 1);
        send_pixels(40, 70, 70, 70, 5);
        // spare register indexes neither change nor restart anything
        write_config(CFG_SPARE_2, 12'($urandom_range(0, 4095)));
        send_pixels(10, 70, 70, 70, 5);
        write_config(CFG_SPARE_3, 12'hFFF);
        send_pixels(5, 70, 70, 70, 5);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(CFG_LINE_WIDTH, 6);
        write_config(CFG_FRAME_HEIGHT, 5);
        hold_req = HOLD_CYCLES;
        send_pixels(30, 60, 60, 60, 0);
        drain_frame();
        send_pixels(15, 60, 60, 60, 0);
        wait_idle();
        send_pixels(15, 60, 60, 60, 0);
        drain_frame();
    endtask

    task automatic test_random_frames(input int unsigned send_pct, recv_pct, target);
        int unsigned first, npix, d_outer, d_segment, d_label;
        bit          broken;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first         = items_done;
        write_random_config();
        while (items_done - first < target) begin
            if ($urandom_range(0, 2) == 0) write_random_config();
            d_outer   = pick_density();
            d_segment = pick_density();
            d_label   = pick_density();
            npix      = eff_width() * eff_height();
            broken    = ($urandom_range(0, 7) == 0);
            if (broken) npix = $urandom_range(1, npix);
            send_pixels(npix, d_outer, d_segment, d_label, 8);
            if (broken) write_random_config();
            else drain_frame();
        end
    endtask

    // result side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result item %h", m_item);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_item.red_out !== want.red_out) begin
                    $error("red_out: expected %0d, actual %0d", want.red_out, m_item.red_out);
                    err_count++;
                end
                if (m_item.green_out !== want.green_out) begin
                    $error("green_out: expected %0d, actual %0d",
                           want.green_out, m_item.green_out);
                    err_count++;
                end
                if (m_item.blue_out !== want.blue_out) begin
                    $error("blue_out: expected %0d, actual %0d", want.blue_out, m_item.blue_out);
                    err_count++;
                end
                if (m_item.border_kind !== want.border_kind) begin
                    $error("border_kind: expected %0d, actual %0d",
                           want.border_kind, m_item.border_kind);
                    err_count++;
                end
                if (m_item.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, actual %0d",
                           want.frame_end, m_item.frame_end);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        width_reg  = 12'd640;
        height_reg = 12'd480;
        restart_frame();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 63;
        test_directed_frames();
        test_register_extremes();
        test_backpressure();
        test_random_frames(8, 63, 360);
        test_random_frames(63, 8, 360);
        test_random_frames(0, 0, 360);
        wait_idle();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
